// ===== src/ocr_pkg.sv =====
package ocr_pkg;

    // Fixed sizes shared by the units: rank word width, fraction bits, padded dims, permutation count.
    localparam int RANK_W    = 64;
    localparam int FRAC_BITS = 16;
    localparam int PAD_DIMS  = 4;
    localparam int NUM_PERMS = 24;

    // Command codes carried by an input word.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Configuration register indexes.
    localparam logic REG_NUM_POINTS = 1'b0;
    localparam logic REG_DIMS       = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [4:0] NUM_POINTS_RST = 5'd16;
    localparam logic [2:0] DIMS_RST       = 3'd2;

    // Top level sequencer.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OBS_INIT,
        ST_OBS_RD,
        ST_OBS_CAP,
        ST_SUB_RD,
        ST_SUB_CAP,
        ST_SIGN_GO,
        ST_SIGN_WAIT,
        ST_COF_GO,
        ST_COF_WAIT,
        ST_NEXT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } t_state;

    // Determinant unit sequencer.
    typedef enum logic [2:0] {
        DS_IDLE,
        DS_PERM,
        DS_FETCH,
        DS_MUL,
        DS_ADD,
        DS_ACC,
        DS_DONE
    } t_det_state;

    // Divider sequencer.
    typedef enum logic [2:0] {
        VS_IDLE,
        VS_RUN,
        VS_RND,
        VS_SAT,
        VS_DONE
    } t_div_state;

    // Column chosen for each row by one permutation; row r sits in bits [2r+1:2r].
    typedef logic [PAD_DIMS-1:0][1:0] t_perm_cols;

    // Matrix entry request from the determinant unit.
    typedef struct packed {
        logic [1:0] row;
        logic [1:0] col;
    } t_det_req;

    // All permutations of four columns in lexicographic order.
    localparam t_perm_cols PERM_COLS [NUM_PERMS] = '{
        {2'd3, 2'd2, 2'd1, 2'd0}, {2'd2, 2'd3, 2'd1, 2'd0},
        {2'd3, 2'd1, 2'd2, 2'd0}, {2'd1, 2'd3, 2'd2, 2'd0},
        {2'd2, 2'd1, 2'd3, 2'd0}, {2'd1, 2'd2, 2'd3, 2'd0},
        {2'd3, 2'd2, 2'd0, 2'd1}, {2'd2, 2'd3, 2'd0, 2'd1},
        {2'd3, 2'd0, 2'd2, 2'd1}, {2'd0, 2'd3, 2'd2, 2'd1},
        {2'd2, 2'd0, 2'd3, 2'd1}, {2'd0, 2'd2, 2'd3, 2'd1},
        {2'd3, 2'd1, 2'd0, 2'd2}, {2'd1, 2'd3, 2'd0, 2'd2},
        {2'd3, 2'd0, 2'd1, 2'd2}, {2'd0, 2'd3, 2'd1, 2'd2},
        {2'd1, 2'd0, 2'd3, 2'd2}, {2'd0, 2'd1, 2'd3, 2'd2},
        {2'd2, 2'd1, 2'd0, 2'd3}, {2'd1, 2'd2, 2'd0, 2'd3},
        {2'd2, 2'd0, 2'd1, 2'd3}, {2'd0, 2'd2, 2'd1, 2'd3},
        {2'd1, 2'd0, 2'd2, 2'd3}, {2'd0, 2'd1, 2'd2, 2'd3}
    };

    // Odd parity of each permutation above, bit i for permutation i.
    localparam logic [NUM_PERMS-1:0] PERM_ODD = 24'b0110_0110_0110_0110_0110_0110;

endpackage

// ===== src/ocr_ram.sv =====
module ocr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ocr_det.sv =====
module ocr_det #(
    parameter int EW = 32,
    parameter int ND = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [2:0]              i_k,
    output ocr_pkg::t_det_req       o_req,
    input  logic signed [EW:0]      i_ent,
    output logic                    o_done,
    output logic signed [ND*EW+5:0] o_det
);

    import ocr_pkg::*;

    localparam int PW = ND * EW;
    localparam int DW = PW + 6;

    t_det_state             r_st;
    t_det_state             n_st;
    logic [4:0]             r_perm;
    logic [1:0]             r_row;
    logic [1:0]             r_limb;
    logic                   r_neg;
    logic [PW-1:0]          r_pm;
    logic [PW-1:0]          r_np;
    logic [EW-1:0]          r_em;
    logic [2*EW-1:0]        r_pp;
    logic signed [DW-1:0]   r_acc;

    logic                   perm_ok;
    logic                   ent_neg;
    logic [EW-1:0]          ent_mag;
    logic [PW-1:0]          np_sum;
    logic signed [DW-1:0]   term;
    logic                   last_row;
    logic                   last_perm;

    // A permutation counts only when it leaves the padding rows on the diagonal.
    always_comb begin
        perm_ok = 1'b1;
        for (int r = 0; r < PAD_DIMS; r++) begin
            if (r >= int'(i_k) && PERM_COLS[r_perm][r] != 2'(r)) begin
                perm_ok = 1'b0;
            end
        end
    end

    // Sign and magnitude of the requested entry, the partial product sum, the signed term and the loop ends.
    always_comb begin
        ent_neg  = i_ent[EW];
        ent_mag  = ent_neg ? EW'(-i_ent) : EW'(i_ent);
        np_sum   = r_np + (PW'(r_pp) << (int'(r_limb) * EW));
        term     = (r_neg ^ PERM_ODD[r_perm]) ? -$signed(DW'(r_pm)) : $signed(DW'(r_pm));
        last_row = 3'(r_row) == i_k - 3'd1;
        last_perm = r_perm == 5'(NUM_PERMS - 1);
    end

    // Next state.
    always_comb begin
        n_st = r_st;
        case (r_st)
            DS_IDLE: begin
                if (i_start) begin
                    n_st = DS_PERM;
                end
            end
            DS_PERM: begin
                if (perm_ok) begin
                    n_st = DS_FETCH;
                end else if (last_perm) begin
                    n_st = DS_DONE;
                end
            end
            DS_FETCH: begin
                if (r_row != 2'd0) begin
                    n_st = DS_MUL;
                end else if (i_k == 3'd1) begin
                    n_st = DS_ACC;
                end
            end
            DS_MUL: n_st = DS_ADD;
            DS_ADD: begin
                if (r_limb == r_row - 2'd1) begin
                    n_st = last_row ? DS_ACC : DS_FETCH;
                end else begin
                    n_st = DS_MUL;
                end
            end
            DS_ACC:  n_st = last_perm ? DS_DONE : DS_PERM;
            DS_DONE: n_st = DS_IDLE;
            default: n_st = DS_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_req.row = r_row;
        o_req.col = PERM_COLS[r_perm][r_row];
        o_done    = r_st == DS_DONE;
        o_det     = r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= DS_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // Product of one permutation is built limb by limb through the shared multiplier.
    always_ff @(posedge i_clk) begin
        case (r_st)
            DS_IDLE: begin
                if (i_start) begin
                    r_acc  <= '0;
                    r_perm <= '0;
                end
            end
            DS_PERM: begin
                if (perm_ok) begin
                    r_row <= 2'd0;
                end else begin
                    r_perm <= r_perm + 5'd1;
                end
            end
            DS_FETCH: begin
                if (r_row == 2'd0) begin
                    r_pm  <= PW'(ent_mag);
                    r_neg <= ent_neg;
                    r_row <= 2'd1;
                end else begin
                    r_em   <= ent_mag;
                    r_neg  <= r_neg ^ ent_neg;
                    r_limb <= 2'd0;
                    r_np   <= '0;
                end
            end
            DS_MUL: begin
                r_pp <= r_pm[int'(r_limb) * EW +: EW] * r_em;
            end
            DS_ADD: begin
                r_np <= np_sum;
                if (r_limb == r_row - 2'd1) begin
                    r_pm  <= np_sum;
                    r_row <= r_row + 2'd1;
                end else begin
                    r_limb <= r_limb + 2'd1;
                end
            end
            DS_ACC: begin
                r_acc  <= r_acc + term;
                r_perm <= r_perm + 5'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== src/ocr_div.sv =====
module ocr_div #(
    parameter int AW   = 175,
    parameter int CW   = 16,
    parameter int ND   = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [AW-1:0] i_num,
    input  logic [CW-1:0]        i_cnt,
    input  logic [2:0]           i_k,
    output logic                 o_done,
    output logic [63:0]          o_quot
);

    import ocr_pkg::*;

    localparam int NUMW = AW + FRAC_BITS;
    localparam int DENW = CW + FRAC_BITS * (ND - 1);
    localparam int QW   = ((NUMW > RANK_W) ? NUMW : RANK_W) + 1;
    localparam int BCW  = $clog2(NUMW + 1);

    t_div_state          r_st;
    t_div_state          n_st;
    logic                r_neg;
    logic [NUMW-1:0]     r_sh;
    logic [DENW-1:0]     r_den;
    logic [DENW-1:0]     r_rem;
    logic [QW-1:0]       r_q;
    logic [BCW-1:0]      r_bits;
    logic [RANK_W-1:0]   r_quot;

    logic [DENW:0]       rem2;
    logic                ge;
    logic [AW-1:0]       mag;

    // One quotient bit per cycle by restoring division.
    always_comb begin
        rem2 = {r_rem, r_sh[NUMW-1]};
        ge   = rem2 >= {1'b0, r_den};
        mag  = i_num[AW-1] ? AW'(-i_num) : AW'(i_num);
    end

    // Next state.
    always_comb begin
        n_st = r_st;
        case (r_st)
            VS_IDLE: begin
                if (i_start) begin
                    n_st = (i_cnt == '0) ? VS_SAT : VS_RUN;
                end
            end
            VS_RUN: begin
                if (r_bits == BCW'(1)) begin
                    n_st = VS_RND;
                end
            end
            VS_RND:  n_st = VS_SAT;
            VS_SAT:  n_st = VS_DONE;
            VS_DONE: n_st = VS_IDLE;
            default: n_st = VS_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_done = r_st == VS_DONE;
        o_quot = r_quot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= VS_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // Datapath: magnitude division, rounding half away from zero, saturation.
    always_ff @(posedge i_clk) begin
        case (r_st)
            VS_IDLE: begin
                if (i_start) begin
                    r_neg  <= i_num[AW-1];
                    r_sh   <= {mag, {FRAC_BITS{1'b0}}};
                    r_den  <= DENW'(i_cnt) << (FRAC_BITS * (int'(i_k) - 1));
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_bits <= BCW'(NUMW);
                end
            end
            VS_RUN: begin
                r_rem  <= ge ? DENW'(rem2 - {1'b0, r_den}) : DENW'(rem2);
                r_q    <= {r_q[QW-2:0], ge};
                r_sh   <= r_sh << 1;
                r_bits <= r_bits - BCW'(1);
            end
            VS_RND: begin
                if ({r_rem, 1'b0} >= {1'b0, r_den}) begin
                    r_q <= r_q + QW'(1);
                end
            end
            VS_SAT: begin
                if (!r_neg) begin
                    if (r_q > QW'(64'h7FFF_FFFF_FFFF_FFFF)) begin
                        r_quot <= 64'h7FFF_FFFF_FFFF_FFFF;
                    end else begin
                        r_quot <= r_q[RANK_W-1:0];
                    end
                end else begin
                    if (r_q > QW'(64'h8000_0000_0000_0000)) begin
                        r_quot <= 64'h8000_0000_0000_0000;
                    end else begin
                        r_quot <= -r_q[RANK_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== src/oja_centered_rank_core.sv =====
// Loading a coordinate leaves the block idle and ready for another word.
// A start keeps the block busy for n * C(n,k) subsets, each needing k*k store reads
// plus one sign determinant and, when that is non-zero, k cofactor determinants.
// Each determinant steps through all 24 permutations on the shared limb multiplier, and
// each of the n*k results then passes through the bit-serial divider.
// Reset is synchronous, active low: num_points returns to 16, dims to 2; the store is not cleared.
module oja_centered_rank_core #(
    parameter int MAX_POINTS  = 16,
    parameter int MAX_DIMS    = 4,
    parameter int COORD_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input word channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [3:0]  i_point_index,
    input  logic [1:0]  i_dim_index,
    input  logic [31:0] i_coord_value,
    // Result word channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_obs_index,
    output logic [1:0]  o_component,
    output logic [63:0] o_rank_value,
    output logic        o_last,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import ocr_pkg::*;

    localparam int EW    = COORD_WIDTH;
    localparam int PW    = MAX_DIMS * EW;
    localparam int DW    = PW + 6;
    localparam int CNT_W = $clog2(MAX_POINTS) * MAX_DIMS;
    localparam int AW    = DW + CNT_W;
    localparam int DEPTH = MAX_POINTS * MAX_DIMS;
    localparam int RAW   = $clog2(DEPTH);

    t_state               r_state;
    t_state               n_state;
    logic [4:0]           r_num_points;
    logic [2:0]           r_dims;
    logic [4:0]           r_n;
    logic [2:0]           r_k;
    logic [4:0]           r_obs;
    logic [4:0]           r_sub [PAD_DIMS];
    logic [1:0]           r_rd_i;
    logic [1:0]           r_rd_j;
    logic [EW-1:0]        r_pr [PAD_DIMS][PAD_DIMS];
    logic [EW-1:0]        r_obs_row [PAD_DIMS];
    logic signed [AW-1:0] r_acc [PAD_DIMS];
    logic [CNT_W-1:0]     r_cnt;
    logic [1:0]           r_u;
    logic                 r_sneg;
    logic                 r_o_valid;
    logic [3:0]           r_o_obs;
    logic [1:0]           r_o_comp;
    logic [63:0]          r_o_rank;
    logic                 r_o_last;

    logic                 in_acc;
    logic                 out_acc;
    logic                 cfg_wr;
    logic [4:0]           n_cl;
    logic [2:0]           k_cl;
    logic                 ram_we;
    logic [RAW-1:0]       ram_waddr;
    logic [RAW-1:0]       ram_raddr;
    logic [EW-1:0]        ram_rdata;
    logic [4:0]           rd_pt;
    logic                 det_start;
    logic                 div_start;
    t_det_req             det_req;
    logic signed [EW:0]   det_ent;
    logic                 det_done;
    logic signed [DW-1:0] det_val;
    logic                 div_done;
    logic [63:0]          div_quot;
    logic [1:0]           jm;
    logic                 sub_more;
    logic [1:0]           piv;
    logic [4:0]           sub_nxt [PAD_DIMS];
    logic signed [AW-1:0] cof_term;
    logic                 last_j;
    logic                 last_i;
    logic                 last_u;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Register clamping applied when a run starts.
    always_comb begin
        n_cl = (int'(r_num_points) > MAX_POINTS) ? 5'(MAX_POINTS) : r_num_points;
        if (r_dims == 3'd0) begin
            k_cl = 3'd1;
        end else if (int'(r_dims) > MAX_DIMS) begin
            k_cl = 3'(MAX_DIMS);
        end else begin
            k_cl = r_dims;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= NUM_POINTS_RST;
            r_dims       <= DIMS_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_NUM_POINTS) begin
                r_num_points <= pwdata[4:0];
            end else begin
                r_dims <= pwdata[2:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_DIMS) ? 32'(r_dims) : 32'(r_num_points);
    assign pready = 1'b1;

    // Coordinate store.
    ocr_ram #(
        .WIDTH(EW),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_coord_value[EW-1:0]),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Shared determinant unit.
    ocr_det #(
        .EW(EW),
        .ND(MAX_DIMS)
    ) u_det (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(det_start),
        .i_k    (r_k),
        .o_req  (det_req),
        .i_ent  (det_ent),
        .o_done (det_done),
        .o_det  (det_val)
    );

    // Averaging divider.
    ocr_div #(
        .AW(AW),
        .CW(CNT_W),
        .ND(MAX_DIMS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (r_acc[r_u]),
        .i_cnt  (r_cnt),
        .i_k    (r_k),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    // Matrix entry: differences for the sign test, a column of ones for cofactors.
    always_comb begin
        jm = ((det_req.col - 2'd1) < r_u) ? det_req.col - 2'd1 : det_req.col;
        if (r_state == ST_SIGN_WAIT) begin
            det_ent = $signed({r_pr[det_req.row][det_req.col][EW-1],
                               r_pr[det_req.row][det_req.col]})
                    - $signed({r_obs_row[det_req.col][EW-1], r_obs_row[det_req.col]});
        end else if (det_req.col == 2'd0) begin
            det_ent = (EW+1)'(1);
        end else begin
            det_ent = $signed({r_pr[det_req.row][jm][EW-1], r_pr[det_req.row][jm]});
        end
    end

    // Next subset in lexicographic order.
    always_comb begin
        sub_more = 1'b0;
        piv      = 2'd0;
        for (int i = 0; i < PAD_DIMS; i++) begin
            if (i < int'(r_k) && int'(r_sub[i]) < int'(r_n) - int'(r_k) + i) begin
                sub_more = 1'b1;
                piv      = 2'(i);
            end
        end
        for (int j = 0; j < PAD_DIMS; j++) begin
            if (j < int'(piv)) begin
                sub_nxt[j] = r_sub[j];
            end else begin
                sub_nxt[j] = 5'(int'(r_sub[piv]) + 1 + j - int'(piv));
            end
        end
    end

    // Loop ends and the signed cofactor contribution.
    always_comb begin
        last_j   = 3'(r_rd_j) == r_k - 3'd1;
        last_i   = 3'(r_rd_i) == r_k - 3'd1;
        last_u   = 3'(r_u) == r_k - 3'd1;
        cof_term = (!r_u[0] ^ r_sneg) ? -AW'(det_val) : AW'(det_val);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_command == CMD_START && n_cl != 5'd0) begin
                    n_state = ST_OBS_INIT;
                end
            end
            ST_OBS_INIT: n_state = ST_OBS_RD;
            ST_OBS_RD:   n_state = ST_OBS_CAP;
            ST_OBS_CAP: begin
                if (!last_j) begin
                    n_state = ST_OBS_RD;
                end else if (int'(r_n) < int'(r_k)) begin
                    n_state = ST_DIV_GO;
                end else begin
                    n_state = ST_SUB_RD;
                end
            end
            ST_SUB_RD:  n_state = ST_SUB_CAP;
            ST_SUB_CAP: n_state = (last_j && last_i) ? ST_SIGN_GO : ST_SUB_RD;
            ST_SIGN_GO: n_state = ST_SIGN_WAIT;
            ST_SIGN_WAIT: begin
                if (det_done) begin
                    n_state = (det_val == '0) ? ST_NEXT : ST_COF_GO;
                end
            end
            ST_COF_GO: n_state = ST_COF_WAIT;
            ST_COF_WAIT: begin
                if (det_done) begin
                    n_state = last_u ? ST_NEXT : ST_COF_GO;
                end
            end
            ST_NEXT:   n_state = sub_more ? ST_SUB_RD : ST_DIV_GO;
            ST_DIV_GO: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    if (!last_u) begin
                        n_state = ST_DIV_GO;
                    end else if (r_obs == r_n - 5'd1) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_OBS_INIT;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_in_stall = r_state != ST_IDLE;
        ram_we     = in_acc && i_command == CMD_LOAD
                  && int'(i_point_index) < MAX_POINTS && int'(i_dim_index) < MAX_DIMS;
        ram_waddr  = RAW'(int'(i_point_index) * MAX_DIMS + int'(i_dim_index));
        rd_pt      = (r_state == ST_OBS_RD) ? r_obs : r_sub[r_rd_i];
        ram_raddr  = RAW'(int'(rd_pt) * MAX_DIMS + int'(r_rd_j));
        det_start  = r_state == ST_SIGN_GO || r_state == ST_COF_GO;
        div_start  = r_state == ST_DIV_GO;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DIV_WAIT && div_done) begin
                r_o_valid <= 1'b1;
            end else if (out_acc) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Working registers of the run.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_command == CMD_START) begin
                    r_n   <= n_cl;
                    r_k   <= k_cl;
                    r_obs <= 5'd0;
                end
            end
            ST_OBS_INIT: begin
                for (int u = 0; u < PAD_DIMS; u++) begin
                    r_acc[u] <= '0;
                    r_sub[u] <= 5'(u);
                end
                r_cnt  <= '0;
                r_rd_i <= 2'd0;
                r_rd_j <= 2'd0;
                r_u    <= 2'd0;
            end
            ST_OBS_CAP: begin
                r_obs_row[r_rd_j] <= ram_rdata;
                r_rd_j <= last_j ? 2'd0 : r_rd_j + 2'd1;
            end
            ST_SUB_CAP: begin
                r_pr[r_rd_i][r_rd_j] <= ram_rdata;
                if (last_j) begin
                    r_rd_j <= 2'd0;
                    r_rd_i <= r_rd_i + 2'd1;
                end else begin
                    r_rd_j <= r_rd_j + 2'd1;
                end
            end
            ST_SIGN_WAIT: begin
                if (det_done) begin
                    r_cnt  <= r_cnt + CNT_W'(1);
                    r_sneg <= det_val[DW-1];
                    r_u    <= 2'd0;
                end
            end
            ST_COF_WAIT: begin
                if (det_done) begin
                    r_acc[r_u] <= r_acc[r_u] + cof_term;
                    r_u <= r_u + 2'd1;
                end
            end
            ST_NEXT: begin
                r_rd_i <= 2'd0;
                r_rd_j <= 2'd0;
                r_u    <= 2'd0;
                if (sub_more) begin
                    for (int j = 0; j < PAD_DIMS; j++) begin
                        r_sub[j] <= sub_nxt[j];
                    end
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    r_o_obs  <= r_obs[3:0];
                    r_o_comp <= r_u;
                    r_o_rank <= div_quot;
                    r_o_last <= (r_obs == r_n - 5'd1) && last_u;
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    if (last_u) begin
                        r_obs <= r_obs + 5'd1;
                    end else begin
                        r_u <= r_u + 2'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid  = r_o_valid;
    assign o_obs_index  = r_o_obs;
    assign o_component  = r_o_comp;
    assign o_rank_value = r_o_rank;
    assign o_last       = r_o_last;

    // A result word is offered exactly while the sequencer waits in its output state.
    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid == (r_state == ST_OUT))
        else $error("result word valid outside the output state");

    // A start with points to process begins the first observation.
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_command == CMD_START && n_cl != 5'd0) |=> r_state == ST_OBS_INIT)
        else $error("start word did not begin a run");

    // Cofactor work and result words never address a component beyond the dimension count.
    a_comp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COF_WAIT || r_state == ST_OUT) |-> 3'(r_u) < r_k)
        else $error("component index out of range");

endmodule

// ===== tb/tb_oja_centered_rank_core.sv =====
`timescale 1ns / 1ps

module tb_oja_centered_rank_core;
    import ocr_pkg::*;

    typedef logic signed [191:0] t_wide;

    typedef struct {
        logic [3:0]  obs;
        logic [1:0]  comp;
        logic [63:0] rank;
        logic        last;
    } t_rank_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_command;
    logic [3:0]  i_point_index;
    logic [1:0]  i_dim_index;
    logic [31:0] i_coord_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [3:0]  o_obs_index;
    logic [1:0]  o_component;
    logic [63:0] o_rank_value;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    oja_centered_rank_core DUT (.*);

    // Predicts the rank words of every start and holds them until they arrive.
    class rank_scoreboard;
        logic signed [31:0] coords [16][4];
        logic [4:0] num_points_reg;
        logic [2:0] dims_reg;
        int unsigned members [4];
        int errors;
        t_rank_word pending [$];

        function new();
            num_points_reg = NUM_POINTS_RST;
            dims_reg = DIMS_RST;
            errors = 0;
            for (int p = 0; p < 16; p++)
                for (int d = 0; d < 4; d++) coords[p][d] = '0;
        endfunction

        function void set_reg(logic reg_idx, logic [31:0] value);
            if (reg_idx == REG_NUM_POINTS) num_points_reg = value[4:0];
            else dims_reg = value[2:0];
        endfunction

        // Exact 4x4 determinant over all column permutations.
        function t_wide det4(t_wide m [4][4]);
            t_wide acc;
            t_wide prod;
            int inv;
            acc = '0;
            for (int a = 0; a < 4; a++)
                for (int b = 0; b < 4; b++)
                    for (int c = 0; c < 4; c++)
                        for (int d = 0; d < 4; d++) begin
                            if (a == b || a == c || a == d || b == c || b == d || c == d)
                                continue;
                            inv = (a > b) + (a > c) + (a > d) + (b > c) + (b > d) + (c > d);
                            prod = m[0][a] * m[1][b] * m[2][c] * m[3][d];
                            if (inv % 2 == 1) acc = acc - prod;
                            else acc = acc + prod;
                        end
            return acc;
        endfunction

        // Steps the subset to its lexicographic successor.
        function bit advance_subset(int unsigned n, int unsigned k);
            for (int i = k - 1; i >= 0; i--) begin
                if (members[i] < n - k + i) begin
                    members[i]++;
                    for (int j = i + 1; j < k; j++) members[j] = members[j - 1] + 1;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // Rounds to nearest with ties away from zero and saturates to 64 bits.
        function logic [63:0] average_rank(t_wide sum, int unsigned cnt, int unsigned k);
            logic [191:0] mag;
            logic [191:0] den;
            logic [191:0] q;
            logic [191:0] r;
            t_wide num;
            bit neg;
            num = sum * 65536;
            neg = num < 0;
            mag = neg ? -num : num;
            den = 192'(cnt) << (16 * (k - 1));
            q = mag / den;
            r = mag % den;
            if (r >= den - r) q = q + 1;
            if (!neg) begin
                if (q > 192'h7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
                return q[63:0];
            end
            if (q > 192'h8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
            return -q[63:0];
        endfunction

        function void note_word(logic cmd, logic [3:0] pt, logic [1:0] dim, logic [31:0] value);
            int unsigned n;
            int unsigned k;
            int unsigned cnt;
            int unsigned col;
            t_wide acc [4];
            t_wide m [4][4];
            t_wide sd;
            t_wide cf;
            t_wide a;
            t_wide b;
            bit more;
            t_rank_word w;
            if (cmd == CMD_LOAD) begin
                coords[pt][dim] = value;
                return;
            end
            n = (num_points_reg > 16) ? 16 : num_points_reg;
            k = (dims_reg < 1) ? 1 : ((dims_reg > 4) ? 4 : dims_reg);
            for (int unsigned obs = 0; obs < n; obs++) begin
                for (int u = 0; u < 4; u++) acc[u] = '0;
                cnt = 0;
                if (n >= k) begin
                    for (int i = 0; i < 4; i++) members[i] = i;
                    more = 1'b1;
                    while (more) begin
                        for (int i = 0; i < 4; i++)
                            for (int j = 0; j < 4; j++) m[i][j] = (i == j) ? 1 : 0;
                        for (int i = 0; i < k; i++)
                            for (int j = 0; j < k; j++) begin
                                a = coords[members[i]][j];
                                b = coords[obs][j];
                                m[i][j] = a - b;
                            end
                        sd = det4(m);
                        cnt++;
                        if (sd != 0) begin
                            for (int u = 0; u < k; u++) begin
                                for (int i = 0; i < k; i++) begin
                                    m[i][0] = 1;
                                    col = 1;
                                    for (int j = 0; j < k; j++)
                                        if (j != u) begin
                                            a = coords[members[i]][j];
                                            m[i][col] = a;
                                            col++;
                                        end
                                end
                                cf = det4(m);
                                if (u % 2 == 0) cf = -cf;
                                if (sd < 0) cf = -cf;
                                acc[u] = acc[u] + cf;
                            end
                        end
                        more = advance_subset(n, k);
                    end
                end
                for (int unsigned u = 0; u < k; u++) begin
                    w.obs = obs[3:0];
                    w.comp = u[1:0];
                    w.rank = (cnt != 0) ? average_rank(acc[u], cnt, k) : 64'd0;
                    w.last = (obs == n - 1) && (u == k - 1);
                    pending.push_back(w);
                end
            end
        endfunction

        task report(string msg);
            $display("ERROR %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [3:0] obs, logic [1:0] comp, logic [63:0] rank, logic last);
            t_rank_word w;
            if (pending.size() == 0) begin
                report($sformatf("unexpected word obs=%0d comp=%0d", obs, comp));
            end else begin
                w = pending.pop_front();
                if (obs !== w.obs)
                    report($sformatf("obs_index %0d, want %0d", obs, w.obs));
                if (comp !== w.comp)
                    report($sformatf("component %0d, want %0d", comp, w.comp));
                if (rank !== w.rank)
                    report($sformatf("rank_value %h, want %h (obs %0d comp %0d)",
                                     rank, w.rank, w.obs, w.comp));
                if (last !== w.last)
                    report($sformatf("last %0b, want %0b", last, w.last));
            end
        endtask
    endclass

    rank_scoreboard rank_sb;
    bit calm;
    int out_hold;
    int words_sent;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Guard against a hung run.
    initial begin
        #60_000_000;
        $display("oja_centered_rank_core: mismatch");
        $finish;
    end

    // Result side: check each accepted word and, unless calm, stall at random.
    always @(posedge i_clk) begin
        int r;
        if (i_rst_n && o_out_valid && !i_out_stall)
            rank_sb.check_result(o_obs_index, o_component, o_rank_value, o_last);
        if (out_hold > 0) begin
            out_hold <= out_hold - 1;
        end else if (calm) begin
            i_out_stall <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                i_out_stall <= 1'b0;
                out_hold <= $urandom_range(0, 5);
            end else if (r < 95) begin
                i_out_stall <= 1'b1;
                out_hold <= $urandom_range(0, 3);
            end else begin
                i_out_stall <= 1'b1;
                out_hold <= $urandom_range(20, 150);
            end
        end
    end

    function int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Presents one word and holds it until the block takes it.
    task send_word(logic cmd, logic [3:0] pt, logic [1:0] dim, logic [31:0] value);
        int gap;
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_point_index <= pt;
        i_dim_index <= dim;
        i_coord_value <= value;
        do @(posedge i_clk); while (o_in_stall);
        rank_sb.note_word(cmd, pt, dim, value);
        words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Waits until every predicted word has come, then lets the block settle.
    task wait_drained();
        i_in_valid <= 1'b0;
        while (rank_sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task reg_write(logic reg_idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= (reg_idx == REG_DIMS) ? 3'd4 : 3'd0;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        rank_sb.set_reg(reg_idx, value);
    endtask

    function logic [31:0] pick_coord(int pt, int dim, bit extreme);
        int r;
        r = $urandom_range(0, 99);
        if (extreme || r < 15) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (r < 35 && pt > 0) return rank_sb.coords[$urandom_range(0, pt - 1)][dim];
        if (r < 75) return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        return $urandom;
    endfunction

    // One setting: write both registers, load every coordinate used, then start.
    task run_setting(logic [31:0] np_val, logic [31:0] dims_val, bit extreme);
        int n;
        int k;
        wait_drained();
        calm = ($urandom_range(0, 3) == 0);
        reg_write(REG_NUM_POINTS, np_val);
        reg_write(REG_DIMS, dims_val);
        n = (np_val[4:0] > 16) ? 16 : np_val[4:0];
        k = (dims_val[2:0] < 1) ? 1 : ((dims_val[2:0] > 4) ? 4 : dims_val[2:0]);
        repeat ($urandom_range(0, 3))
            send_word(CMD_LOAD, 4'($urandom), 2'($urandom), $urandom);
        for (int p = 0; p < n; p++)
            for (int d = 0; d < k; d++)
                send_word(CMD_LOAD, p[3:0], d[1:0], pick_coord(p, d, extreme));
        send_word(CMD_START, 4'($urandom), 2'($urandom), $urandom);
    endtask

    // Stimulus.
    initial begin
        int k;
        int lim;
        rank_sb = new();
        calm = 1'b0;
        out_hold = 0;
        words_sent = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_command <= CMD_LOAD;
        i_point_index <= '0;
        i_dim_index <= '0;
        i_coord_value <= '0;
        i_out_stall <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: no points, a single point, fewer points than dims,
        // four dims clamped from seven with extreme coordinates, and the
        // point count clamped from 31 with dims clamped up from zero.
        run_setting(32'd0, 32'd1, 1'b0);
        run_setting(32'd1, 32'd1, 1'b0);
        run_setting(32'd2, 32'd3, 1'b0);
        run_setting(32'd4, 32'd7, 1'b1);
        run_setting(32'd31, 32'd0, 1'b0);

        // Random settings, kept small so that each start stays short.
        while (words_sent < 160) begin
            k = $urandom_range(1, 4);
            case (k)
                1: lim = 16;
                2: lim = 7;
                3: lim = 6;
                default: lim = 5;
            endcase
            run_setting($urandom_range(1, lim), k, $urandom_range(0, 9) == 0);
        end

        wait_drained();
        if (rank_sb.errors == 0) begin
            $display("oja_centered_rank_core: match");
        end else begin
            $display("oja_centered_rank_core: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/ocr_pkg.sv
src/ocr_ram.sv
src/ocr_det.sv
src/ocr_div.sv
src/oja_centered_rank_core.sv
tb/tb_oja_centered_rank_core.sv
